// ----- design/ssi_prc_pkg.sv -----
// Shared types and constants for the scanner parameter reply checker.
// No dependencies; every other design file imports this package.
package ssi_prc_pkg;

  // One input beat: a received frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_beat_t;

  // One result beat, given once per frame on its final byte.
  typedef struct packed {
    logic [1:0]  check_status;
    logic        fields_valid;
    logic [23:0] param_number;
    logic [15:0] param_value;
  } out_beat_t;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_CSUM_ERR  = 2'd2;

  // Frame layout.
  localparam logic [7:0] SHORT_FRAME = 8'd10;
  localparam logic [7:0] LONG_FRAME  = 8'd12;
  localparam logic [7:0] OPCODE_POS  = 8'd1;
  localparam logic [7:0] FIELD_FIRST = 8'd5;
  localparam int         FIELD_COUNT = 5;
  localparam logic [7:0] FIELD_END   = 8'd10;

  // Saturation point of the byte counter.
  localparam logic [7:0] COUNT_LIMIT = 8'd255;

  // Reset value of the expected opcode register.
  localparam logic [7:0] OPCODE_RESET = 8'd198;

endpackage

// ----- design/ssi_prc_in_stage.sv -----
// Input register stage of the reply checker: holds one accepted byte beat.
// Depends on ssi_prc_pkg for the input beat type.
module ssi_prc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssi_prc_pkg::in_beat_t in_beat,
  input  logic                 advance,
  output logic                 stage_valid,
  output ssi_prc_pkg::in_beat_t stage_beat
);
  import ssi_prc_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // The stage takes a new beat when it is empty or its beat moves on now.
  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ----- design/ssi_prc_frame.sv -----
// Frame state and evaluation: byte count, running sum, opcode and field bytes,
// plus the status and field decode for the final byte. Depends on ssi_prc_pkg.
module ssi_prc_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  ssi_prc_pkg::in_beat_t beat,
  input  logic [7:0]            expected_opcode,
  output ssi_prc_pkg::out_beat_t result
);
  import ssi_prc_pkg::*;

  logic [7:0]  count_r;
  logic [15:0] sum_r;
  logic [7:0]  recent0_r;
  logic [7:0]  recent1_r;
  logic [7:0]  opcode_r;
  logic [7:0]  field_r [FIELD_COUNT];

  logic [7:0]  count_nxt;
  logic [15:0] sum_nxt;
  logic [7:0]  opcode_nxt;
  logic [15:0] total;
  logic [2:0]  field_idx;
  logic        field_wr;

  // Next values of the frame state for the byte in the stage.
  always_comb begin
    sum_nxt    = (count_r >= 8'd2) ? 16'(sum_r + {8'd0, recent0_r}) : sum_r;
    opcode_nxt = (count_r == OPCODE_POS) ? beat.frame_byte : opcode_r;
    count_nxt  = (count_r < COUNT_LIMIT) ? 8'(count_r + 8'd1) : count_r;
    field_idx  = 3'(count_r - FIELD_FIRST);
    field_wr   = (count_r >= FIELD_FIRST) && (count_r < FIELD_END);
    // The last two bytes form a big-endian word added to the sum.
    total      = 16'(sum_nxt + {recent1_r, beat.frame_byte});
  end

  // Status and field decode; the fields read were all written in earlier beats.
  always_comb begin
    result.fields_valid = 1'b0;
    result.param_number = 24'd0;
    result.param_value  = 16'd0;
    priority if (count_nxt < SHORT_FRAME || opcode_nxt != expected_opcode) begin
      result.check_status = STATUS_MALFORMED;
    end else if (total != 16'd0) begin
      result.check_status = STATUS_CSUM_ERR;
    end else begin
      result.check_status = STATUS_OK;
      if (count_nxt == SHORT_FRAME) begin
        result.fields_valid = 1'b1;
        result.param_number = {8'd0, field_r[0], field_r[1]};
        result.param_value  = {8'd0, field_r[2]};
      end else if (count_nxt == LONG_FRAME) begin
        result.fields_valid = 1'b1;
        result.param_number = {field_r[0], field_r[1], field_r[2]};
        result.param_value  = {field_r[3], field_r[4]};
      end
    end
  end

  // Frame state: cleared at reset and after the final byte of each frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 8'd0;
      sum_r     <= 16'd0;
      recent0_r <= 8'd0;
      recent1_r <= 8'd0;
      opcode_r  <= 8'd0;
    end else if (step) begin
      if (beat.end_of_frame) begin
        count_r   <= 8'd0;
        sum_r     <= 16'd0;
        recent0_r <= 8'd0;
        recent1_r <= 8'd0;
        opcode_r  <= 8'd0;
      end else begin
        count_r   <= count_nxt;
        sum_r     <= sum_nxt;
        recent0_r <= recent1_r;
        recent1_r <= beat.frame_byte;
        opcode_r  <= opcode_nxt;
      end
    end
  end

  // Field bytes keep their contents across frames and need no reset.
  always_ff @(posedge clk) begin
    if (step && field_wr) begin
      field_r[field_idx] <= beat.frame_byte;
    end
  end

endmodule

// ----- design/ssi_prc_out_stage.sv -----
// Output register of the reply checker: holds one result beat until taken.
// Depends on ssi_prc_pkg for the result beat type.
module ssi_prc_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  ssi_prc_pkg::out_beat_t load_beat,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ssi_prc_pkg::out_beat_t out_beat
);
  import ssi_prc_pkg::*;

  logic      valid_r;
  out_beat_t beat_r;

  // A new result fits when the register is empty or is being taken now.
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= load_beat;
    end
  end

endmodule

// ----- design/ssi_param_reply_checker_core.sv -----
// Scanner parameter reply checker: byte stream in, one check result per frame.
// Channels: in_valid/in_ready carry one frame byte per beat with an
// end-of-frame flag on the final byte. out_valid/out_ready carry one result
// beat per frame (status, fields_valid, parameter number and value).
// cfg_valid/cfg_ready write the expected opcode; cfg_ready is always high
// and the register should only be written while no frame is in progress.
// Path: a final byte is registered in the input stage, goes through the frame
// logic and is registered in the output stage, which drives out_valid.
// Throughput is one byte per cycle, but a final byte waits while the output is full.
// Bytes that do not end a frame give no result beat.
// Reset: synchronous, active low. It empties both registers, clears the byte
// count, running sum and opcode, and sets the expected opcode to 198.
// Stall: while out_ready is low a waiting result is held; further non-final
// bytes keep flowing, and input stops only when a second final byte
// finds the output register still full.
// Depends on ssi_prc_pkg and the in_stage, frame and out_stage modules.
module ssi_param_reply_checker_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ssi_prc_pkg::in_beat_t  in_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ssi_prc_pkg::out_beat_t out_beat,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);
  import ssi_prc_pkg::*;

  logic      stage_valid;
  in_beat_t  stage_beat;
  logic      advance;
  logic      can_load;
  out_beat_t result;
  logic [7:0] opcode_r;

  // Expected opcode register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r <= OPCODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      opcode_r <= cfg_data;
    end
  end

  // A staged byte moves on unless it ends a frame and the output is full.
  assign advance = stage_valid && (!stage_beat.end_of_frame || can_load);

  ssi_prc_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_beat  (stage_beat)
  );

  ssi_prc_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .beat            (stage_beat),
    .expected_opcode (opcode_r),
    .result          (result)
  );

  ssi_prc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && stage_beat.end_of_frame),
    .load_beat (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
